[rtl/rcs_pkg.sv]
// Shared types and constants for the random cell sampler.
// Holds field widths, the status codes and the divider control struct.
// Used by the serial divider and the top level; depends on nothing.
package rcs_pkg;

  localparam int MAX_CELLS_DEF = 4096;
  localparam int RAND_W        = 31;
  localparam int GRID_W        = 13;
  localparam int CELL_W        = 12;
  localparam int EPOCH_W       = 4;
  localparam int NBITS_W       = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RESET     = 2'd2
  } status_t;

  typedef struct packed {
    logic               start;
    logic [NBITS_W-1:0] nbits;
  } div_ctl_t;

endpackage

[rtl/random_cell_sampler_without_replacement_unit.sv]
// Random cell sampler: uniform grid cell picks without repetition (lazy swap table).
// A flip runs the serial modulo by the live count, then the two table reads and the
// write, then the serial row/column split.
// A reset item re-runs the clearing pass over the table when the epoch tag wraps.
// After rst a clearing pass runs over the whole table; no word is accepted during
// it. Depends on rcs_pkg, rcs_ram and rcs_serdiv.
module random_cell_sampler_without_replacement_unit #(
  parameter int MAX_CELLS = rcs_pkg::MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: rand_value [30:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // s_tuser: func [0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: cell_row [11:0], cell_col [23:12]
  output logic [23:0] m_tdata,
  // m_tuser: status [1:0]
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcs_pkg::*;

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int DVS_W = (CNT_W > GRID_W) ? CNT_W : GRID_W;
  localparam int MEM_W = EPOCH_W + IDX_W;
  localparam int PROD_W = 2 * GRID_W;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_MOD, S_RDA, S_RDB, S_WR, S_DIV, S_OUT
  } state_t;

  state_t              state;
  logic [GRID_W-1:0]   rows;
  logic [GRID_W-1:0]   cols;
  logic [CNT_W-1:0]    count;
  logic [EPOCH_W-1:0]  epoch;
  logic [IDX_W-1:0]    sweep_addr;
  logic                sweep_res;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    cell_num;
  logic [CELL_W-1:0]   res_row;
  logic [CELL_W-1:0]   res_col;
  status_t             res_status;

  logic                accept;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    last_cell;
  logic                rd_hit;
  logic [PROD_W-1:0]   prod;
  logic [CNT_W-1:0]    total;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [MEM_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [MEM_W-1:0]    ram_rdata;

  div_ctl_t            div_ctl;
  logic [RAND_W-1:0]   div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic                div_done;
  logic [RAND_W-1:0]   div_quo;
  logic [DVS_W-1:0]    div_rem;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign prdata   = paddr[2] ? 32'(cols) : 32'(rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= GRID_W'(1);
      cols <= GRID_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        cols <= pwdata[GRID_W-1:0];
      end else begin
        rows <= pwdata[GRID_W-1:0];
      end
    end
  end

  always_comb begin
    last_idx  = IDX_W'(count - 1'b1);
    rd_hit    = (ram_rdata[MEM_W-1:IDX_W] == epoch);
    last_cell = rd_hit ? ram_rdata[IDX_W-1:0] : last_idx;
    prod      = PROD_W'(rows) * PROD_W'(cols);
    total     = (prod > PROD_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : prod[CNT_W-1:0];

    ram_we    = (state == S_SWEEP) || (state == S_WR);
    ram_waddr = (state == S_SWEEP) ? sweep_addr : idx;
    ram_wdata = (state == S_SWEEP) ? '0 : {epoch, last_cell};
    ram_raddr = (state == S_RDA) ? idx : last_idx;

    div_ctl.start = (accept && !s_tuser[0] && (count != '0)) ||
                    ((state == S_WR) && (cols != '0));
    if (state == S_IDLE) begin
      div_ctl.nbits = NBITS_W'(RAND_W);
      div_dividend  = s_tdata[RAND_W-1:0];
      div_divisor   = DVS_W'(count);
    end else begin
      div_ctl.nbits = NBITS_W'(IDX_W);
      div_dividend  = RAND_W'(cell_num) << (RAND_W - IDX_W);
      div_divisor   = DVS_W'(cols);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      sweep_res  <= 1'b0;
      epoch      <= EPOCH_W'(1);
      count      <= CNT_W'(1);
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_addr == IDX_W'(MAX_CELLS - 1)) begin
            sweep_addr <= '0;
            epoch      <= EPOCH_W'(1);
            sweep_res  <= 1'b0;
            state      <= sweep_res ? S_OUT : S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_row <= '0;
            res_col <= '0;
            if (s_tuser[0]) begin
              count      <= total;
              res_status <= ST_RESET;
              if (epoch == '1) begin
                sweep_res <= 1'b1;
                state     <= S_SWEEP;
              end else begin
                epoch <= epoch + 1'b1;
                state <= S_OUT;
              end
            end else if (count == '0) begin
              res_status <= ST_EXHAUSTED;
              state      <= S_OUT;
            end else begin
              res_status <= ST_OK;
              state      <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (div_done) begin
            idx   <= div_rem[IDX_W-1:0];
            state <= S_RDA;
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          cell_num <= rd_hit ? ram_rdata[IDX_W-1:0] : idx;
          state    <= S_WR;
        end
        S_WR: begin
          count <= count - 1'b1;
          if (cols == '0) begin
            res_col <= CELL_W'(cell_num);
            state   <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_row <= CELL_W'(div_quo[IDX_W-1:0]);
            res_col <= CELL_W'(div_rem);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_col, res_row};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rcs_ram #(
    .WIDTH(MEM_W),
    .DEPTH(MAX_CELLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rcs_serdiv #(
    .DVD_W(RAND_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

endmodule

[rtl/rcs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No reset on the storage; depends on nothing.
module rcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rcs_serdiv.sv]
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// The dividend is consumed from its top bit for the requested number of bits.
// Depends on rcs_pkg.
module rcs_serdiv #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  rcs_pkg::div_ctl_t ctl,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient,
  output logic [DVS_W-1:0]  remainder
);
  import rcs_pkg::*;

  logic               busy;
  logic [NBITS_W-1:0] cnt;
  logic [DVD_W-1:0]   sh;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     diff;
  logic               ge;

  always_comb begin
    trial = {remainder, sh[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= ctl.nbits;
      sh        <= dividend;
      dvs       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (busy) begin
      sh        <= {sh[DVD_W-2:0], 1'b0};
      remainder <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient  <= {quotient[DVD_W-2:0], ge};
      cnt       <= cnt - 1'b1;
      if (cnt == NBITS_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
